[design/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned NumHash = 5;
  localparam int unsigned NumWin  = 16;

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  localparam logic [WordW-1:0] H_INIT [NumHash] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_LEN_BLK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic       byte_wr;
    logic       pad_wr;
    logic       len_blk;
    logic       load;
    logic       round;
    logic       add;
    logic       clear;
    phase_t     phase;
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_hi;
  } status_t;

  function automatic logic [WordW-1:0] round_f(phase_t ph, logic [WordW-1:0] b,
                                               logic [WordW-1:0] c,
                                               logic [WordW-1:0] d);
    logic [WordW-1:0] r;
    case (ph)
      PH_CH:   r = (b & c) ^ (~b & d);
      PH_MAJ:  r = (b & c) ^ (b & d) ^ (c & d);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic logic [WordW-1:0] round_k(phase_t ph);
    logic [WordW-1:0] r;
    case (ph)
      PH_CH:   r = K0;
      PH_PAR1: r = K1;
      PH_MAJ:  r = K2;
      default: r = K3;
    endcase
    return r;
  endfunction

endpackage

[design/sha1_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_tlast,
  input  sha1_pkg::status_t  status,
  output sha1_pkg::cmd_t     cmd
);

  sha1_pkg::state_t state_r, state_nxt;
  logic [6:0]       round_r, round_nxt;
  logic             fin_r, fin_nxt;
  logic             len_pend_r, len_pend_nxt;
  logic [2:0]       idx_r, idx_nxt;

  logic in_acc, out_acc, last_round, last_word;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign last_round = (round_r == 7'(sha1_pkg::Rounds - 1));
  assign last_word  = (idx_r == 3'(sha1_pkg::NumHash - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha1_pkg::ST_IDLE;
      round_r    <= '0;
      fin_r      <= 1'b0;
      len_pend_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      round_r    <= round_nxt;
      fin_r      <= fin_nxt;
      len_pend_r <= len_pend_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    round_nxt    = round_r;
    fin_nxt      = fin_r;
    len_pend_nxt = len_pend_r;
    idx_nxt      = idx_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == sha1_pkg::KIND_FINISH) begin
            fin_nxt      = 1'b1;
            len_pend_nxt = status.pos_hi;
            state_nxt    = sha1_pkg::ST_LOAD;
          end else if (status.pos_last) begin
            state_nxt = sha1_pkg::ST_LOAD;
          end
        end
      end
      sha1_pkg::ST_LOAD: begin
        round_nxt = '0;
        state_nxt = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        round_nxt = round_r + 7'd1;
        if (last_round) state_nxt = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        if (len_pend_r) begin
          state_nxt = sha1_pkg::ST_LEN_BLK;
        end else if (fin_r) begin
          idx_nxt   = '0;
          state_nxt = sha1_pkg::ST_EMIT;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_LEN_BLK: begin
        len_pend_nxt = 1'b0;
        state_nxt    = sha1_pkg::ST_LOAD;
      end
      sha1_pkg::ST_EMIT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (last_word) begin
            fin_nxt   = 1'b0;
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.word_idx = idx_r;
    if (round_r < 7'd20)      cmd.phase = sha1_pkg::PH_CH;
    else if (round_r < 7'd40) cmd.phase = sha1_pkg::PH_PAR1;
    else if (round_r < 7'd60) cmd.phase = sha1_pkg::PH_MAJ;
    else                      cmd.phase = sha1_pkg::PH_PAR2;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_tready   = rst_n;
        cmd.byte_wr = in_acc && (in_tuser == sha1_pkg::KIND_DATA);
        cmd.pad_wr  = in_acc && (in_tuser == sha1_pkg::KIND_FINISH);
      end
      sha1_pkg::ST_LOAD:    cmd.load    = 1'b1;
      sha1_pkg::ST_ROUND:   cmd.round   = 1'b1;
      sha1_pkg::ST_ADD:     cmd.add     = 1'b1;
      sha1_pkg::ST_LEN_BLK: cmd.len_blk = 1'b1;
      sha1_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tlast  = last_word;
        cmd.clear  = out_acc && last_word;
      end
      default: ;
    endcase
  end

endmodule

[design/sha1_dpath.sv]
// ----------------------------------------------------------------------------
// sha1_dpath
// Block window, length counter, chaining words and the shared round unit.
// ----------------------------------------------------------------------------
module sha1_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::cmd_t    cmd,
  input  logic [7:0]        data_byte,
  output sha1_pkg::status_t status,
  output logic [31:0]       digest_word
);

  logic [31:0] win_r [sha1_pkg::NumWin];
  logic [31:0] win_nxt [sha1_pkg::NumWin];
  logic [31:0] h_r [sha1_pkg::NumHash];
  logic [31:0] v_r [sha1_pkg::NumHash];
  logic [5:0]  pos_r;
  logic [63:0] bits_r;

  logic [31:0] a, w_mix, w_new, t_sum;
  logic [3:0]  pos_word;
  logic [1:0]  pos_lane;

  assign pos_word = pos_r[5:2];
  assign pos_lane = pos_r[1:0];
  assign a        = v_r[0];
  assign w_mix    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new    = {w_mix[30:0], w_mix[31]};
  assign t_sum    = {a[26:0], a[31:27]}
                  + sha1_pkg::round_f(cmd.phase, v_r[1], v_r[2], v_r[3])
                  + v_r[4] + sha1_pkg::round_k(cmd.phase) + win_r[0];

  assign status.pos_last = (pos_r == 6'd63);
  assign status.pos_hi   = (pos_r >= 6'd56);
  assign digest_word     = h_r[cmd.word_idx];

  // window next value
  always_comb begin
    for (int i = 0; i < sha1_pkg::NumWin; i++) win_nxt[i] = win_r[i];
    if (cmd.byte_wr) begin
      case (pos_lane)
        2'd0:    win_nxt[pos_word][31:24] = data_byte;
        2'd1:    win_nxt[pos_word][23:16] = data_byte;
        2'd2:    win_nxt[pos_word][15:8]  = data_byte;
        default: win_nxt[pos_word][7:0]   = data_byte;
      endcase
    end else if (cmd.pad_wr) begin
      for (int i = 0; i < sha1_pkg::NumWin; i++) begin
        for (int b = 0; b < 4; b++) begin
          if (6'(i * 4 + b) == pos_r)
            win_nxt[i][31-8*b -: 8] = sha1_pkg::PAD_BYTE;
          else if (6'(i * 4 + b) > pos_r)
            win_nxt[i][31-8*b -: 8] = 8'h00;
        end
      end
      if (!status.pos_hi) begin
        win_nxt[14] = bits_r[63:32];
        win_nxt[15] = bits_r[31:0];
      end
    end else if (cmd.len_blk) begin
      for (int i = 0; i < sha1_pkg::NumWin; i++) win_nxt[i] = '0;
      win_nxt[14] = bits_r[63:32];
      win_nxt[15] = bits_r[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < sha1_pkg::NumWin - 1; i++) win_nxt[i] = win_r[i+1];
      win_nxt[sha1_pkg::NumWin-1] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sha1_pkg::NumWin; i++) win_r[i] <= win_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < sha1_pkg::NumHash; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[0] <= t_sum;
      v_r[1] <= a;
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < sha1_pkg::NumHash; i++) h_r[i] <= sha1_pkg::H_INIT[i];
      pos_r  <= '0;
      bits_r <= '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < sha1_pkg::NumHash; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.byte_wr) begin
        pos_r  <= pos_r + 6'd1;
        bits_r <= bits_r + 64'd8;
      end
    end
  end

endmodule

[design/sha1_hash_engine_core.sv]
// ----------------------------------------------------------------------------
// sha1_hash_engine_core
// SHA-1 engine taking one message byte per transaction.
// ----------------------------------------------------------------------------
// Input channel: in_tdata carries a message byte, in_tuser selects data (0)
// or finish (1). Data bytes are packed big-endian into a 64-byte block.
// The 64th byte of a block starts a compression (load, 80 rounds of the
// single round unit, chaining add) before the next byte is taken.
// Finish pads the block and compresses it, with an extra block when the
// length field does not fit, then sends five digest words on the output
// channel, word 0 first, out_tlast on word 4.
// in_tready is low while compressing or emitting. A stalled receiver holds
// the current digest word stable; the engine waits without losing state.
// After the last word is taken the engine restarts for the next message.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the byte and bit counters; in_tready rises as soon as rst_n is high.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;
  logic [31:0]       digest_word;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .status     (status),
    .cmd        (cmd)
  );

  sha1_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .status      (status),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'd0, cmd.word_idx, digest_word};

endmodule

[sim/sha1_hash_engine_core_test.sv]
// ----------------------------------------------------------------------------
// sha1_hash_engine_core_test
// Self-checking bench for the byte-serial SHA-1 engine. Messages of edge and
// random lengths are streamed in with random gaps; an in-bench SHA-1 model
// predicts each digest, and every output transaction is compared with it.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandItems  = 147;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  msg_item_t    msg_items_q[$];
  digest_beat_t digest_q[$];

  logic [31:0] hash_st [sha1_pkg::NumHash];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  logic        in_fire = 1'b0;
  int unsigned items_in = 0;
  int unsigned bytes_in = 0;
  int unsigned msgs_done = 0;
  int unsigned words_checked = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        quiet;

  sha1_hash_engine_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  assign quiet = (items_in >= 60) && (items_in < 140);

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_restart();
    for (int i = 0; i < sha1_pkg::NumHash; i++) hash_st[i] = sha1_pkg::H_INIT[i];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic sha1_compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d; hash_st[4] += e;
  endtask

  // one accepted transaction into the digest model
  task automatic sha1_absorb(logic kind, logic [7:0] data);
    digest_beat_t beat;
    if (kind == sha1_pkg::KIND_DATA) begin
      blk_bytes[blk_fill] = data;
      msg_bits += 64'd8;
      blk_fill++;
      if (blk_fill == 64) begin
        sha1_compress_block();
        blk_fill = 0;
      end
    end else begin
      blk_bytes[blk_fill] = sha1_pkg::PAD_BYTE;
      blk_fill++;
      if (blk_fill > 56) begin
        while (blk_fill < 64) begin
          blk_bytes[blk_fill] = 8'h00;
          blk_fill++;
        end
        sha1_compress_block();
        blk_fill = 0;
      end
      while (blk_fill < 56) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
      sha1_compress_block();
      for (int i = 0; i < sha1_pkg::NumHash; i++) begin
        beat.word = hash_st[i];
        beat.idx  = 3'(i);
        beat.last = (i == sha1_pkg::NumHash - 1);
        digest_q.push_back(beat);
      end
      sha1_restart();
    end
  endtask

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // input driver
  always @(negedge clk) begin
    msg_item_t it;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (msg_items_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
        it = msg_items_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.data;
        in_tuser  <= it.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off while a digest is pending
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && out_tvalid && msgs_done >= 4) begin
      out_tready <= 1'b0;
      hold_left  <= HoldCycles;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      sha1_absorb(in_tuser, in_tdata);
      items_in <= items_in + 1;
      if (in_tuser == sha1_pkg::KIND_DATA) bytes_in <= bytes_in + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_error($sformatf("unexpected digest transaction %h last %0b",
                               out_tdata, out_tlast));
      end else begin
        exp_beat = digest_q.pop_front();
        words_checked <= words_checked + 1;
        if (out_tdata[31:0] !== exp_beat.word || out_tdata[34:32] !== exp_beat.idx ||
            out_tlast !== exp_beat.last)
          report_error($sformatf("exp word %h idx %0d last %0b, got %h idx %0d last %0b",
                                 exp_beat.word, exp_beat.idx, exp_beat.last,
                                 out_tdata[31:0], out_tdata[34:32], out_tlast));
        if (exp_beat.last) msgs_done <= msgs_done + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_item(logic kind, logic [7:0] data);
    msg_item_t it;
    it.kind = kind;
    it.data = data;
    msg_items_q.push_back(it);
  endtask

  task automatic add_msg(int unsigned len);
    for (int unsigned i = 0; i < len; i++) add_item(sha1_pkg::KIND_DATA, 8'($urandom));
    add_item(sha1_pkg::KIND_FINISH, 8'($urandom));
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned len;
    int unsigned pick;
    sha1_restart();

    // directed: empty message, "abc", single-byte extremes, back-to-back finish
    add_item(sha1_pkg::KIND_FINISH, 8'h00);
    add_item(sha1_pkg::KIND_DATA, 8'h61);
    add_item(sha1_pkg::KIND_DATA, 8'h62);
    add_item(sha1_pkg::KIND_DATA, 8'h63);
    add_item(sha1_pkg::KIND_FINISH, 8'hff);
    add_item(sha1_pkg::KIND_DATA, 8'h00);
    add_item(sha1_pkg::KIND_FINISH, 8'h00);
    add_item(sha1_pkg::KIND_DATA, 8'hff);
    add_item(sha1_pkg::KIND_FINISH, 8'hff);
    add_item(sha1_pkg::KIND_DATA, 8'h55);
    add_item(sha1_pkg::KIND_DATA, 8'haa);
    add_item(sha1_pkg::KIND_FINISH, 8'h5a);
    add_item(sha1_pkg::KIND_FINISH, 8'ha5);

    // random messages; lengths favor short ones and the block boundaries
    rand_items = 0;
    while (rand_items < RandItems) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(12);
      end else if (pick < 80) begin
        len = $urandom_range(70, 50);
      end else begin
        case ($urandom_range(6))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 119;
          default: len = 128;
        endcase
      end
      if (len + 1 > RandItems - rand_items) len = RandItems - rand_items - 1;
      add_msg(len);
      rand_items += len + 1;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (msg_items_q.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("%0d messages (%0d bytes, %0d transactions) hashed, %0d digest words checked",
             msgs_done, bytes_in, items_in, words_checked);
    $display("lengths covered empty, short, pad boundaries and multi-block; %0d errors",
             errors);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/sha1_pkg.sv
design/sha1_ctrl.sv
design/sha1_dpath.sv
design/sha1_hash_engine_core.sv
sim/sha1_hash_engine_core_test.sv
